### design/mcdi_pkg.sv
`timescale 1ns / 1ps

package mcdi_pkg;

    localparam int INDEX_BITS = 24;
    localparam int CNT_W      = INDEX_BITS - 1;
    localparam int KEY_W      = INDEX_BITS + 1;
    localparam int OUT_IDX_W  = 23;
    localparam int VN_W       = 10;
    localparam int STATUS_W   = 2;
    localparam int REG_IDX_W  = 2;
    localparam int HASH_W     = 64;
    localparam int MUL_W      = 32;
    localparam int HASH_FOLD_SHIFT = 29;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int HASH_SLOTS_DEF   = 2048;

    localparam logic [MUL_W-1:0] HASH_P_MUL = 32'h9E3779B1;
    localparam logic [MUL_W-1:0] HASH_T_ADD = 32'h7F4A7C15;
    localparam logic [MUL_W-1:0] HASH_T_MUL = 32'h85EBCA77;
    localparam logic [MUL_W-1:0] HASH_N_ADD = 32'h165667B1;
    localparam logic [MUL_W-1:0] HASH_N_MUL = 32'hC2B2AE3D;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POS_RANGE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_POSITION_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEXCOORD_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL_COUNT   = 2'd2;

    typedef enum logic [2:0] {
        HOP_IDLE   = 3'd0,
        HOP_MUL_P  = 3'd1,
        HOP_MUL_T  = 3'd2,
        HOP_MUL_N  = 3'd3,
        HOP_FOLD   = 3'd4,
        HOP_REDUCE = 3'd5
    } hash_op_t;

    typedef struct packed {
        logic [KEY_W-1:0] norm;
        logic [KEY_W-1:0] tex;
        logic [KEY_W-1:0] pos;
    } key_triple_t;

endpackage

### design/mcdi_hash_unit.sv
`timescale 1ns / 1ps

module mcdi_hash_unit
    import mcdi_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF,
    localparam int SLOT_W = $clog2(HASH_SLOTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hash_op_t          op,
    input  key_triple_t       keys,
    output logic [SLOT_W-1:0] slot,
    output logic              done
);

    localparam bit SLOTS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;

    logic [HASH_W-1:0] h_reg;
    logic [MUL_W-1:0]  t_off_reg;
    logic [MUL_W-1:0]  n_off_reg;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [HASH_W-1:0] product;

    always_comb
    begin
        case (op)
            HOP_MUL_T:
            begin
                mul_a = t_off_reg;
                mul_b = HASH_T_MUL;
            end
            HOP_MUL_N:
            begin
                mul_a = n_off_reg;
                mul_b = HASH_N_MUL;
            end
            default:
            begin
                mul_a = MUL_W'(keys.pos);
                mul_b = HASH_P_MUL;
            end
        endcase
    end

    assign product = HASH_W'(mul_a) * HASH_W'(mul_b);

    always_ff @(posedge clk)
    begin
        case (op)
            HOP_MUL_P:
            begin
                h_reg     <= product;
                t_off_reg <= MUL_W'(keys.tex) + HASH_T_ADD;
                n_off_reg <= MUL_W'(keys.norm) + HASH_N_ADD;
            end
            HOP_MUL_T, HOP_MUL_N:
            begin
                h_reg <= h_reg ^ product;
            end
            HOP_FOLD:
            begin
                h_reg <= h_reg ^ (h_reg >> HASH_FOLD_SHIFT);
            end
            HOP_REDUCE:
            begin
                h_reg <= h_reg << 1;
            end
            default:
            begin
                h_reg <= h_reg;
            end
        endcase
    end

    generate
        if (SLOTS_POW2)
        begin : g_mask
            assign slot = h_reg[SLOT_W-1:0];
            assign done = 1'b1;
        end
        else
        begin : g_reduce
            localparam int CNT_BITS = $clog2(HASH_W);
            localparam logic [SLOT_W:0] SLOTS_V = (SLOT_W + 1)'(HASH_SLOTS);

            logic [SLOT_W-1:0]   rem_reg;
            logic [CNT_BITS-1:0] cnt_reg;
            logic                done_reg;
            logic [SLOT_W:0]     trial;

            // Restoring remainder, one bit of the hash per cycle from the top.
            assign trial = {rem_reg, h_reg[HASH_W-1]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    done_reg <= 1'b0;
                end
                else if (op == HOP_FOLD)
                begin
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    done_reg <= 1'b0;
                end
                else if (op == HOP_REDUCE && !done_reg)
                begin
                    if (trial >= SLOTS_V)
                    begin
                        rem_reg <= SLOT_W'(trial - SLOTS_V);
                    end
                    else
                    begin
                        rem_reg <= SLOT_W'(trial);
                    end
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(HASH_W - 1))
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end

            assign slot = rem_reg;
            assign done = done_reg;
        end
    endgenerate

endmodule

### design/mcdi_slot_table.sv
`timescale 1ns / 1ps

module mcdi_slot_table
    import mcdi_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF,
    parameter int VID_W      = $clog2(MAX_VERTICES_DEF),
    localparam int SLOT_W = $clog2(HASH_SLOTS)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic              wr_valid,
    input  key_triple_t       wr_keys,
    input  logic [VID_W-1:0]  wr_vid,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic              rd_valid,
    output key_triple_t       rd_keys,
    output logic [VID_W-1:0]  rd_vid
);

    localparam int WORD_W = 1 + $bits(key_triple_t) + VID_W;

    logic [WORD_W-1:0] mem [HASH_SLOTS];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_valid, wr_keys, wr_vid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign {rd_valid, rd_keys, rd_vid} = rd_word_reg;

endmodule

### design/mesh_corner_dedup_indexer.sv
`timescale 1ns / 1ps

// Resolves the raw position, texture and normal indices of one face corner and
// deduplicates the resolved triple in a linear-probed hash table, returning the
// vertex number and whether it was newly created. One request is handled at a
// time: it is resolved, hashed and folded, then probed slot by slot, each probe
// a read and a check, with a store when a new vertex is made, and the next
// request is taken once the result is registered; a position out of range skips
// the hash and the table. The hash is built by a single shared 32 by 32
// multiplier in three passes, and each probe is one read of the slot memory,
// which has separate read and write ports. With a slot count that is not a
// power of two the slot is reduced one hash bit per cycle over all 64 bits of
// the hash. After reset a clearing pass writes every slot in turn to empty the
// table, during which no request is taken; configuration writes are taken at
// all times.
module mesh_corner_dedup_indexer
    import mcdi_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int HASH_SLOTS   = HASH_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_raw [23:0], tex_raw [47:24], norm_raw [71:48]
    input  logic [71:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // vertex_number [9:0], pos_index [32:10], tex_index [55:33],
    // norm_index [78:56], zero [79]
    output logic [79:0]          m_tdata,
    // is_new [0], tex_present [1], norm_present [2], status [4:3]
    output logic [4:0]           m_tuser
);

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int MADE_W = $clog2(MAX_VERTICES + 1);
    localparam bit SLOTS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HASH_SLOTS - 1);
    localparam logic [MADE_W-1:0] MAX_V = MADE_W'(MAX_VERTICES);

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b000000000001,
        ST_IDLE    = 12'b000000000010,
        ST_RESOLVE = 12'b000000000100,
        ST_HASH_P  = 12'b000000001000,
        ST_HASH_T  = 12'b000000010000,
        ST_HASH_N  = 12'b000000100000,
        ST_FOLD    = 12'b000001000000,
        ST_REDUCE  = 12'b000010000000,
        ST_READ    = 12'b000100000000,
        ST_CHECK   = 12'b001000000000,
        ST_INSERT  = 12'b010000000000,
        ST_DONE    = 12'b100000000000
    } state_t;

    function automatic logic [KEY_W-1:0] resolve_idx(input logic [INDEX_BITS-1:0] raw,
                                                      input logic [CNT_W-1:0] count);
        logic [KEY_W-1:0] s;
        logic [KEY_W-1:0] k;
        s = {raw[INDEX_BITS-1], raw};
        if (raw == '0)
        begin
            k = '1;
        end
        else if (!raw[INDEX_BITS-1])
        begin
            k = s - KEY_W'(1);
        end
        else
        begin
            k = KEY_W'(count) + s;
        end
        return k;
    endfunction

    function automatic logic idx_in_range(input logic [KEY_W-1:0] k,
                                          input logic [CNT_W-1:0] count);
        return !k[KEY_W-1] && (k[KEY_W-2:0] < (KEY_W - 1)'(count));
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] position_count_reg;
    logic [CNT_W-1:0] texcoord_count_reg;
    logic [CNT_W-1:0] normal_count_reg;

    logic [INDEX_BITS-1:0] pos_raw_reg;
    logic [INDEX_BITS-1:0] tex_raw_reg;
    logic [INDEX_BITS-1:0] norm_raw_reg;

    key_triple_t keys_reg;
    logic [KEY_W-1:0] pos_key;
    logic [KEY_W-1:0] tex_key;
    logic [KEY_W-1:0] norm_key;
    logic             pos_ok;
    logic             tex_ok;
    logic             norm_ok;

    logic [SLOT_W-1:0] clr_addr_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] probe_cnt_reg;
    logic [MADE_W-1:0] made_reg;

    logic [VN_W-1:0]      res_vnum_reg;
    logic                 res_new_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [OUT_IDX_W-1:0] res_pos_idx_reg;
    logic [OUT_IDX_W-1:0] res_tex_idx_reg;
    logic                 res_tex_ok_reg;
    logic [OUT_IDX_W-1:0] res_norm_idx_reg;
    logic                 res_norm_ok_reg;

    logic                 m_tvalid_reg;
    logic [VN_W-1:0]      out_vnum_reg;
    logic                 out_new_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [OUT_IDX_W-1:0] out_pos_idx_reg;
    logic [OUT_IDX_W-1:0] out_tex_idx_reg;
    logic                 out_tex_ok_reg;
    logic [OUT_IDX_W-1:0] out_norm_idx_reg;
    logic                 out_norm_ok_reg;

    hash_op_t          hash_op;
    logic [SLOT_W-1:0] hash_slot;
    logic              hash_done;

    logic              tbl_wr_en;
    logic [SLOT_W-1:0] tbl_wr_addr;
    logic              tbl_rd_en;
    logic [SLOT_W-1:0] tbl_rd_addr;
    logic              tbl_rd_valid;
    key_triple_t       tbl_rd_keys;
    logic [VID_W-1:0]  tbl_rd_vid;

    logic in_accept;
    logic out_load;
    logic key_match;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_count_reg <= '0;
            texcoord_count_reg <= '0;
            normal_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POSITION_COUNT: position_count_reg <= cfg_data;
                REG_TEXCOORD_COUNT: texcoord_count_reg <= cfg_data;
                REG_NORMAL_COUNT:   normal_count_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign pos_key  = resolve_idx(pos_raw_reg, position_count_reg);
    assign tex_key  = resolve_idx(tex_raw_reg, texcoord_count_reg);
    assign norm_key = resolve_idx(norm_raw_reg, normal_count_reg);
    assign pos_ok   = idx_in_range(pos_key, position_count_reg);
    assign tex_ok   = idx_in_range(tex_key, texcoord_count_reg);
    assign norm_ok  = idx_in_range(norm_key, normal_count_reg);

    assign key_match = (tbl_rd_keys == keys_reg);

    always_comb
    begin
        state_next = state_reg;
        hash_op    = HOP_IDLE;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = pos_ok ? ST_HASH_P : ST_DONE;
            end
            ST_HASH_P:
            begin
                hash_op    = HOP_MUL_P;
                state_next = ST_HASH_T;
            end
            ST_HASH_T:
            begin
                hash_op    = HOP_MUL_T;
                state_next = ST_HASH_N;
            end
            ST_HASH_N:
            begin
                hash_op    = HOP_MUL_N;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                hash_op    = HOP_FOLD;
                state_next = SLOTS_POW2 ? ST_READ : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                hash_op = HOP_REDUCE;
                if (hash_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!tbl_rd_valid)
                begin
                    state_next = (made_reg >= MAX_V) ? ST_DONE : ST_INSERT;
                end
                else if (key_match || probe_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            probe_cnt_reg <= '0;
            made_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
            if (state_reg == ST_FOLD)
            begin
                probe_cnt_reg <= '0;
            end
            else if (state_reg == ST_CHECK && tbl_rd_valid && !key_match)
            begin
                probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
            end
            if (state_reg == ST_INSERT)
            begin
                made_reg <= made_reg + MADE_W'(1);
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_raw_reg  <= s_tdata[23:0];
            tex_raw_reg  <= s_tdata[47:24];
            norm_raw_reg <= s_tdata[71:48];
        end
        case (state_reg)
            ST_RESOLVE:
            begin
                keys_reg.pos     <= pos_key;
                keys_reg.tex     <= tex_key;
                keys_reg.norm    <= norm_key;
                res_vnum_reg     <= '0;
                res_new_reg      <= 1'b0;
                res_status_reg   <= pos_ok ? STATUS_OK : STATUS_POS_RANGE;
                res_pos_idx_reg  <= pos_ok ? pos_key[OUT_IDX_W-1:0] : '0;
                res_tex_idx_reg  <= tex_ok ? tex_key[OUT_IDX_W-1:0] : '0;
                res_tex_ok_reg   <= tex_ok;
                res_norm_idx_reg <= norm_ok ? norm_key[OUT_IDX_W-1:0] : '0;
                res_norm_ok_reg  <= norm_ok;
            end
            ST_READ:
            begin
                slot_reg <= tbl_rd_addr;
            end
            ST_CHECK:
            begin
                if (!tbl_rd_valid)
                begin
                    if (made_reg >= MAX_V)
                    begin
                        res_status_reg <= STATUS_FULL;
                    end
                end
                else if (key_match)
                begin
                    res_vnum_reg <= VN_W'(tbl_rd_vid);
                end
                else if (probe_cnt_reg == LAST_SLOT)
                begin
                    res_status_reg <= STATUS_FULL;
                end
                else
                begin
                    slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            ST_INSERT:
            begin
                res_vnum_reg <= VN_W'(made_reg);
                res_new_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_vnum_reg     <= res_vnum_reg;
            out_new_reg      <= res_new_reg;
            out_status_reg   <= res_status_reg;
            out_pos_idx_reg  <= res_pos_idx_reg;
            out_tex_idx_reg  <= res_tex_idx_reg;
            out_tex_ok_reg   <= res_tex_ok_reg;
            out_norm_idx_reg <= res_norm_idx_reg;
            out_norm_ok_reg  <= res_norm_ok_reg;
        end
    end

    // The first probe takes the slot straight from the hash unit.
    assign tbl_rd_en   = (state_reg == ST_READ);
    assign tbl_rd_addr = (probe_cnt_reg == '0) ? hash_slot : slot_reg;
    assign tbl_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_INSERT);
    assign tbl_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : slot_reg;

    mcdi_hash_unit #(
        .HASH_SLOTS (HASH_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (hash_op),
        .keys  (keys_reg),
        .slot  (hash_slot),
        .done  (hash_done)
    );

    mcdi_slot_table #(
        .HASH_SLOTS (HASH_SLOTS),
        .VID_W      (VID_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_valid (state_reg == ST_INSERT),
        .wr_keys  (keys_reg),
        .wr_vid   (VID_W'(made_reg)),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_valid (tbl_rd_valid),
        .rd_keys  (tbl_rd_keys),
        .rd_vid   (tbl_rd_vid)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_norm_idx_reg, out_tex_idx_reg, out_pos_idx_reg, out_vnum_reg};
    assign m_tuser  = {out_status_reg, out_norm_ok_reg, out_tex_ok_reg, out_new_reg};

    a_made_bound: assert property (@(posedge clk) disable iff (!rst_n)
        made_reg <= MAX_V)
        else $error("Vertex count has passed its limit.");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INSERT |-> made_reg < MAX_V)
        else $error("Vertex stored although the vertex limit was reached.");

    a_made_step: assert property (@(posedge clk) disable iff (!rst_n)
        made_reg != $past(made_reg) |-> $past(state_reg) == ST_INSERT)
        else $error("Vertex count moved without a store.");

    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && out_new_reg |-> out_status_reg == STATUS_OK)
        else $error("New vertex reported with an error status.");

    a_accept_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_RESOLVE)
        else $error("Accepted request did not move on to resolution.");

endmodule
